### hdl/tksq_pkg.sv
// Types and constants of the two-key sorted priority queue.
// Depends on nothing; read first by every file that imports it.
`default_nettype none

package tksq_pkg;

	typedef struct packed {
		logic [2:0]  prio;
		logic [10:0] arr;
		logic [7:0]  tag;
	} entry_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef struct packed {
		logic insert;
		logic remove;
	} cell_ctl_t;

	localparam int OCC_W = 5;

endpackage

`default_nettype wire

### hdl/tksq_req_if.sv
// Request channel of the priority queue: valid, ready and one access.
// Depends on nothing.
`default_nettype none

interface tksq_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [2:0]  entry_priority;
	logic [10:0] arrival_minute;
	logic [7:0]  entry_tag;

	modport source (output valid, action, entry_priority, arrival_minute, entry_tag,
		input ready);
	modport sink (input valid, action, entry_priority, arrival_minute, entry_tag,
		output ready);
endinterface

`default_nettype wire

### hdl/tksq_rsp_if.sv
// Response channel of the priority queue: valid, ready and one result.
// Depends on nothing.
`default_nettype none

interface tksq_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        head_valid;
	logic [2:0]  head_priority;
	logic [10:0] head_arrival;
	logic [7:0]  head_tag;
	logic [4:0]  occupancy;

	modport source (output valid, status, head_valid, head_priority, head_arrival,
		head_tag, occupancy, input ready);
	modport sink (input valid, status, head_valid, head_priority, head_arrival,
		head_tag, occupancy, output ready);
endinterface

`default_nettype wire

### hdl/tksq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the new key
// and loads from its neighbours. Depends on tksq_pkg.
`default_nettype none

module tksq_cell
	import tksq_pkg::*;
(
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      occ,
	input  wire entry_t    new_entry,
	input  wire entry_t    prev_entry,
	input  wire logic      prev_ins,
	input  wire entry_t    next_entry,
	output entry_t         entry,
	output logic           ins
);

	entry_t entry_q;
	logic   ahead;

	always_comb begin
		ahead = (entry_q.prio < new_entry.prio) ||
			((entry_q.prio == new_entry.prio) && (entry_q.arr > new_entry.arr));
		ins = ahead || !occ;
	end

	always_ff @(posedge clk) begin
		if (ctl.insert && ins) begin
			entry_q <= prev_ins ? prev_entry : new_entry;
		end else if (ctl.remove) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

### hdl/two_key_sorted_priority_queue.sv
// Two-key sorted priority queue built as a chain of compare-and-shift cells.
// Depends on tksq_pkg, tksq_req_if, tksq_rsp_if and tksq_cell.
//
// Usage:
//   req carries one access: action 0 inserts (entry_priority, arrival_minute,
//   entry_tag), action 1 removes the head. Higher priority is served first,
//   earlier arrival first within a priority, equal keys in arrival order.
//   rsp returns one result per access: status (ok, full, empty), the removed
//   head when head_valid is set, and the occupancy after the access.
//   Every cell compares its entry with the new key in parallel and either
//   holds, takes its upper neighbour, takes the new entry or takes its lower
//   neighbour, so an access completes in the cycle it is accepted.
//   The result is registered and presented in the cycle after acceptance.
//   One access per cycle, set by the cell update, while no result is held or rsp.ready is high.
//   The response register holds a result while rsp.ready is low; req.ready
//   is then low too, so nothing is lost. A new access is taken in the same
//   cycle the held result is taken.
//   Reset empties the queue (entry count to zero, no result pending); cell
//   contents are not cleared and are never read while unoccupied.
`default_nettype none

module two_key_sorted_priority_queue
	import tksq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tksq_req_if.sink   req,
	tksq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	status_t          status_q;
	logic             head_valid_q;
	entry_t           head_q;

	logic      accept;
	logic      full;
	logic      empty;
	cell_ctl_t ctl;
	entry_t    new_entry;
	entry_t    cell_entry [QUEUE_DEPTH];
	logic      cell_ins   [QUEUE_DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	assign new_entry = '{prio: req.entry_priority, arr: req.arrival_minute,
		tag: req.entry_tag};

	always_comb begin
		ctl.insert = accept && (req.action == ACT_INSERT) && !full;
		ctl.remove = accept && (req.action == ACT_REMOVE) && !empty;
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t prev_e;
		logic   prev_i;
		entry_t next_e;

		if (i == 0) begin : g_first
			assign prev_e = new_entry;
			assign prev_i = 1'b0;
		end else begin : g_mid
			assign prev_e = cell_entry[i-1];
			assign prev_i = cell_ins[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_e = cell_entry[i];
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end

		tksq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (CNT_W'(i) < count_q),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_ins   (prev_i),
			.next_entry (next_e),
			.entry      (cell_entry[i]),
			.ins        (cell_ins[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.remove) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_valid_q <= ctl.remove;
			head_q       <= ctl.remove ? cell_entry[0] : '0;
			case (req.action)
				ACT_INSERT: status_q <= full ? ST_FULL : ST_OK;
				ACT_REMOVE: status_q <= empty ? ST_EMPTY : ST_OK;
				default:    status_q <= ST_OK;
			endcase
		end
	end

	logic [CNT_W-1:0] occ_now;
	assign occ_now = count_q;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.head_valid    = head_valid_q;
	assign rsp.head_priority = head_q.prio;
	assign rsp.head_arrival  = head_q.arr;
	assign rsp.head_tag      = head_q.tag;
	assign rsp.occupancy     = OCC_W'(occ_now);

endmodule

`default_nettype wire

### tb/tksq_monitor.sv
`timescale 1ns / 1ps
// Watches both channels of the priority queue, keeps its own sorted copy of
// the entries and compares every result. Depends on tksq_pkg and both channel interfaces.

module tksq_monitor
	import tksq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tksq_req_if       req,
	tksq_rsp_if       rsp,
	output int        mismatch_count,
	output int        results_due
);

	typedef struct {
		status_t          status;
		logic             head_valid;
		entry_t           head;
		logic [OCC_W-1:0] occupancy;
	} result_t;

	entry_t  queued_entries[$];
	result_t due_results[$];
	int      mismatches = 0;

	assign mismatch_count = mismatches;

	function automatic result_t serve_access(action_t act, entry_t item);
		result_t r;
		int      pos;
		r.status     = ST_OK;
		r.head_valid = 1'b0;
		r.head       = '0;
		if (act == ACT_INSERT) begin
			if (queued_entries.size() >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// stand behind higher priority, behind earlier arrival at equal priority and behind equal keys that came first
				pos = 0;
				while (pos < queued_entries.size() &&
					!(queued_entries[pos].prio < item.prio ||
					(queued_entries[pos].prio == item.prio &&
					queued_entries[pos].arr > item.arr)))
					pos++;
				queued_entries.insert(pos, item);
			end
		end else begin
			if (queued_entries.size() == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.head_valid = 1'b1;
				r.head       = queued_entries.pop_front();
			end
		end
		r.occupancy = OCC_W'(queued_entries.size());
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		entry_t  item;
		if (!arst_n) begin
			queued_entries.delete();
			due_results.delete();
			results_due <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$error("result transaction with no access outstanding");
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("status", 32'(want.status), 32'(rsp.status));
					check_field("head_valid", 32'(want.head_valid), 32'(rsp.head_valid));
					check_field("head_priority", 32'(want.head.prio),
						32'(rsp.head_priority));
					check_field("head_arrival", 32'(want.head.arr),
						32'(rsp.head_arrival));
					check_field("head_tag", 32'(want.head.tag), 32'(rsp.head_tag));
					check_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
				end
			end
			if (req.valid && req.ready) begin
				item.prio = req.entry_priority;
				item.arr  = req.arrival_minute;
				item.tag  = req.entry_tag;
				due_results.push_back(serve_access(action_t'(req.action), item));
			end
			results_due <= due_results.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the two-key sorted priority queue.
// Depends on tksq_pkg, both channel interfaces, the block and tksq_monitor.

module tb_top;
	import tksq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int LONG_HOLD   = 80;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_requests;
	int   mismatch_count;
	int   results_due;

	tksq_req_if req_ch ();
	tksq_rsp_if rsp_ch ();

	two_key_sorted_priority_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	tksq_monitor #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.mismatch_count(mismatch_count),
		.results_due   (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int holds_done;
		int hold_left;
		holds_done = 0;
		hold_left  = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_access(action_t act, logic [2:0] prio, logic [10:0] arr,
		logic [7:0] tag);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.action         <= act;
		req_ch.entry_priority <= prio;
		req_ch.arrival_minute <= arr;
		req_ch.entry_tag      <= tag;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
	endtask

	task automatic run_random(int count);
		int         insert_pct;
		bit         narrow;
		action_t    act;
		logic [2:0] prio;
		logic [10:0] arr;
		insert_pct = 50;
		narrow     = 1'b0;
		for (int n = 0; n < count; n++) begin
			if (n % 24 == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 85;
					1: insert_pct = 50;
					default: insert_pct = 20;
				endcase
				narrow = 1'($urandom_range(0, 1));
			end
			act  = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
			prio = narrow ? 3'($urandom_range(3, 4)) : 3'($urandom_range(0, 7));
			case ($urandom_range(0, 3))
				0: arr = 11'($urandom_range(0, 3));
				1: arr = 11'($urandom_range(0, 2047));
				default: arr = 11'($urandom_range(0, 1439));
			endcase
			send_access(act, prio, arr, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		arst_n                <= 1'b0;
		req_ch.valid          <= 1'b0;
		req_ch.action         <= ACT_INSERT;
		req_ch.entry_priority <= '0;
		req_ch.arrival_minute <= '0;
		req_ch.entry_tag      <= '0;
		hold_requests         <= 0;
		recv_idle_pct         <= 64;
		send_idle_pct = 7;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_access(ACT_REMOVE, 3'd7, 11'd2047, 8'd255);
		send_access(ACT_INSERT, 3'd0, 11'd0, 8'd0);
		send_access(ACT_INSERT, 3'd7, 11'd2047, 8'd255);
		send_access(ACT_INSERT, 3'd7, 11'd0, 8'hAA);
		send_access(ACT_INSERT, 3'd7, 11'd2047, 8'h55);
		send_access(ACT_INSERT, 3'd3, 11'd100, 8'd1);
		send_access(ACT_INSERT, 3'd3, 11'd50, 8'd2);
		send_access(ACT_INSERT, 3'd3, 11'd100, 8'd3);
		send_access(ACT_INSERT, 3'd0, 11'd1439, 8'd4);
		for (int n = 0; n < 9; n++)
			send_access(ACT_REMOVE, 3'd0, 11'd0, 8'd0);

		run_random(240);

		// hold the receiver while inserts wait on it, then pause until all returned
		hold_requests <= hold_requests + 1;
		for (int n = 0; n < 20; n++)
			send_access(ACT_INSERT, 3'($urandom_range(0, 7)),
				11'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
		wait_drained();

		send_idle_pct = 64;
		recv_idle_pct <= 7;
		run_random(240);

		send_idle_pct = 0;
		recv_idle_pct <= 0;
		run_random(230);

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
